@@ sv/fac_pkg.sv @@
package fac_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 14;
    localparam int TAG_W      = 10;
    localparam int OFF_W      = 4;
    localparam int DATA_W     = 8;
    localparam int LFSR_W     = 16;
    localparam int LINE_BYTES = 16;
    localparam int CNT_W      = 5;

    // Defaults for the top-level parameters
    localparam int NUM_LINES_DEF = 64;
    localparam int MEM_BYTES_DEF = 16384;

    // Replacement LFSR
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic div_step;
        logic lfsr_adv;
        logic vtag_read;
        logic base_load;
        logic base_sel_new;
        logic wb_step;
        logic fill_step;
        logic install;
        logic access;
        logic resp;
        logic clear_step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic hit;
        logic div_last;
        logic victim_dirty;
        logic sweep_done;
    } t_sts;

endpackage

@@ sv/fac_dp.sv @@
module fac_dp #(
    parameter int NUM_LINES = 64,
    parameter int MEM_BYTES = 16384
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fac_pkg::t_cmd               i_cmd,
    output fac_pkg::t_sts               o_sts,
    input  logic                        i_cfg_valid,
    input  logic [fac_pkg::LFSR_W-1:0]  i_cfg_data,
    input  logic                        i_operation,
    input  logic [fac_pkg::ADDR_W-1:0]  i_address,
    input  logic [fac_pkg::DATA_W-1:0]  i_write_data,
    output logic [fac_pkg::DATA_W-1:0]  o_read_data,
    output logic                        o_hit,
    output logic                        o_wrote_back
);
    import fac_pkg::*;

    localparam int LI_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int REM_W = $clog2(NUM_LINES) + 1;
    localparam int MA_W  = $clog2(MEM_BYTES);
    localparam int LA_W  = LI_W + OFF_W;
    localparam int RECIP = 65536 / NUM_LINES;

    // Request registers
    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;
    logic [TAG_W-1:0]  req_tag;
    logic [OFF_W-1:0]  req_off;

    // Line directory
    logic [TAG_W-1:0]     r_tag [NUM_LINES];
    logic [NUM_LINES-1:0] r_valid;
    logic [NUM_LINES-1:0] r_dirty;
    logic [TAG_W-1:0]     m_tag [NUM_LINES];
    logic [TAG_W-1:0]     r_vtag;

    // Working registers
    logic [LI_W-1:0]   r_line;
    logic              r_hit;
    logic              r_wb;
    logic [REM_W-1:0]  r_rem;
    logic [LFSR_W-1:0] r_q;
    logic [LFSR_W-1:0] r_lfsr;
    logic [CNT_W-1:0]  r_cnt;
    logic [MA_W-1:0]   r_maddr;

    // Memories
    logic [DATA_W-1:0] m_line [NUM_LINES*LINE_BYTES];
    logic [DATA_W-1:0] m_back [MEM_BYTES];
    logic [DATA_W-1:0] r_line_q;
    logic [DATA_W-1:0] r_back_q;

    logic              hit_any;
    logic [LI_W-1:0]   hit_idx;
    logic [31:0]       div_prod;
    logic [31:0]       div_qn;
    logic [REM_W-1:0]  n_rem;
    logic [LI_W-1:0]   vidx;
    logic [LA_W-1:0]   la_addr;
    logic              la_we;
    logic              la_re;
    logic [DATA_W-1:0] la_wd;
    logic              mb_we;
    logic              mb_re;
    logic [DATA_W-1:0] mb_wd;
    logic [MA_W-1:0]   maddr_inc;
    logic [MA_W-1:0]   base_v;
    logic              cnt_nz;
    logic              cnt_lt16;

    assign req_tag = r_addr[ADDR_W-1:OFF_W];
    assign req_off = r_addr[OFF_W-1:0];
    assign vidx    = r_rem[LI_W-1:0];
    assign cnt_nz  = (r_cnt != '0);
    assign cnt_lt16 = !r_cnt[CNT_W-1];

    // Byte address of a line's first byte, reduced into the backing memory
    function automatic logic [MA_W-1:0] mem_base(input logic [TAG_W-1:0] tg);
        logic [31:0] v;
        v = 32'({tg, {OFF_W{1'b0}}});
        for (int k = 4; k >= 0; k--) begin
            if (v >= (32'(MEM_BYTES) << k)) begin
                v = v - (32'(MEM_BYTES) << k);
            end
        end
        return v[MA_W-1:0];
    endfunction

    assign base_v    = mem_base(i_cmd.base_sel_new ? req_tag : r_vtag);
    assign maddr_inc = (r_maddr == MA_W'(MEM_BYTES - 1)) ? '0 : r_maddr + 1'b1;

    // Associative match, lowest line wins
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = NUM_LINES - 1; k >= 0; k--) begin
            if (r_valid[k] && (r_tag[k] == req_tag)) begin
                hit_any = 1'b1;
                hit_idx = LI_W'(k);
            end
        end
    end

    // lfsr mod NUM_LINES: reciprocal estimate (low by at most one), then one correction
    assign div_prod = 32'(r_lfsr) * 32'(RECIP);
    assign div_qn   = 32'(r_q) * 32'(NUM_LINES);
    assign n_rem    = (r_rem >= REM_W'(NUM_LINES)) ? r_rem - REM_W'(NUM_LINES) : r_rem;

    assign o_sts.clear_done   = (r_maddr == MA_W'(MEM_BYTES - 1));
    assign o_sts.hit          = hit_any;
    assign o_sts.div_last     = (r_cnt == CNT_W'(2));
    assign o_sts.victim_dirty = r_wb;
    assign o_sts.sweep_done   = r_cnt[CNT_W-1];

    // Request capture and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (i_cmd.lookup) begin
            r_hit  <= hit_any;
            r_line <= hit_idx;
        end
        if (i_cmd.vtag_read) begin
            r_line <= vidx;
        end
        if (i_cmd.resp) begin
            o_read_data  <= (r_op == OP_WRITE) ? r_wdata : r_line_q;
            o_hit        <= r_hit;
            o_wrote_back <= r_wb;
        end
    end

    // Victim flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wb <= 1'b0;
        end else if (i_cmd.vtag_read) begin
            r_wb <= r_valid[vidx] & r_dirty[vidx];
        end
    end

    // Step counter and victim pick
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup || i_cmd.base_load) begin
            r_cnt <= '0;
            r_rem <= '0;
        end else if (i_cmd.div_step || i_cmd.wb_step || i_cmd.fill_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (i_cmd.div_step) begin
                case (r_cnt[1:0])
                    2'd0: begin
                        r_q <= div_prod[31:16];
                    end
                    2'd1: begin
                        r_rem <= REM_W'(32'(r_lfsr) - div_qn);
                    end
                    default: begin
                        r_rem <= n_rem;
                    end
                endcase
            end
        end
    end

    // Replacement LFSR
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_lfsr <= (i_cfg_data == '0) ? LFSR_W'(1) : i_cfg_data;
        end else if (i_cmd.lfsr_adv) begin
            r_lfsr <= r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);
        end
    end

    // Directory flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else if (i_cmd.install) begin
            r_valid[r_line] <= 1'b1;
            r_dirty[r_line] <= 1'b0;
        end else if (i_cmd.access && (r_op == OP_WRITE)) begin
            r_dirty[r_line] <= 1'b1;
        end
    end

    // Tags: flops for matching, a RAM copy for the victim read
    always_ff @(posedge i_clk) begin
        if (i_cmd.install) begin
            r_tag[r_line] <= req_tag;
            m_tag[r_line] <= req_tag;
        end
        if (i_cmd.vtag_read) begin
            r_vtag <= m_tag[vidx];
        end
    end

    // Line data RAM port
    always_comb begin
        la_addr = {r_line, req_off};
        la_we   = 1'b0;
        la_re   = 1'b0;
        la_wd   = r_wdata;
        if (i_cmd.wb_step) begin
            la_addr = {r_line, r_cnt[3:0]};
            la_re   = cnt_lt16;
        end else if (i_cmd.fill_step) begin
            la_addr = {r_line, 4'(r_cnt - 1'b1)};
            la_we   = cnt_nz;
            la_wd   = r_back_q;
        end else if (i_cmd.access) begin
            la_we = (r_op == OP_WRITE);
            la_re = (r_op == OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (la_we) begin
            m_line[la_addr] <= la_wd;
        end
        if (la_re) begin
            r_line_q <= m_line[la_addr];
        end
    end

    // Backing memory port
    assign mb_we = i_cmd.clear_step || (i_cmd.wb_step && cnt_nz);
    assign mb_re = i_cmd.fill_step && cnt_lt16;
    assign mb_wd = i_cmd.clear_step ? '0 : r_line_q;

    always_ff @(posedge i_clk) begin
        if (mb_we) begin
            m_back[r_maddr] <= mb_wd;
        end
        if (mb_re) begin
            r_back_q <= m_back[r_maddr];
        end
    end

    // Backing memory address walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maddr <= '0;
        end else if (i_cmd.base_load) begin
            r_maddr <= base_v;
        end else if (mb_we || mb_re) begin
            r_maddr <= maddr_inc;
        end
    end

endmodule

@@ sv/fac_ctrl.sv @@
module fac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  fac_pkg::t_sts i_sts,
    output fac_pkg::t_cmd o_cmd
);
    import fac_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_LOOKUP = 11'b000_0000_0100,
        S_VDIV   = 11'b000_0000_1000,
        S_VTAG   = 11'b000_0001_0000,
        S_WBASE  = 11'b000_0010_0000,
        S_WB     = 11'b000_0100_0000,
        S_FBASE  = 11'b000_1000_0000,
        S_FILL   = 11'b001_0000_0000,
        S_ACCESS = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign slot_free   = !(r_out_valid && i_out_stall);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = i_sts.hit ? S_ACCESS : S_VDIV;
            end
            S_VDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    o_cmd.lfsr_adv = 1'b1;
                    n_state = S_VTAG;
                end
            end
            S_VTAG: begin
                o_cmd.vtag_read = 1'b1;
                n_state = S_WBASE;
            end
            S_WBASE: begin
                o_cmd.base_load    = 1'b1;
                o_cmd.base_sel_new = !i_sts.victim_dirty;
                n_state = i_sts.victim_dirty ? S_WB : S_FILL;
            end
            S_WB: begin
                o_cmd.wb_step = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_FBASE;
                end
            end
            S_FBASE: begin
                o_cmd.base_load    = 1'b1;
                o_cmd.base_sel_new = 1'b1;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.sweep_done) begin
                    o_cmd.install = 1'b1;
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                o_cmd.access = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (slot_free) begin
                    o_cmd.resp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Output slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.resp) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ sv/fully_assoc_writeback_cache.sv @@
// Hit: lookup, line access and a registered result; the input is accepted again once the result is
// registered. Miss: the victim pick (LFSR mod NUM_LINES by reciprocal multiply), then a write-back
// when the victim is dirty, then a line fill through the single-port backing memory. A held result
// stalls. Reset (synchronous, active low) clears the directory and reloads the LFSR, then sweeps
// the backing memory to zero, one byte a cycle, with the input stalled.
module fully_assoc_writeback_cache #(
    parameter int NUM_LINES = fac_pkg::NUM_LINES_DEF,
    parameter int MEM_BYTES = fac_pkg::MEM_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [fac_pkg::ADDR_W-1:0]  i_address,
    input  logic [fac_pkg::DATA_W-1:0]  i_write_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [fac_pkg::DATA_W-1:0]  o_read_data,
    output logic                        o_hit,
    output logic                        o_wrote_back,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fac_pkg::LFSR_W-1:0]  i_cfg_data
);
    import fac_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The seed port never stalls
    assign o_cfg_ready = 1'b1;

    // Sequencer
    fac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Directory, line store and backing memory
    fac_dp #(
        .NUM_LINES (NUM_LINES),
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_read_data  (o_read_data),
        .o_hit        (o_hit),
        .o_wrote_back (o_wrote_back)
    );

endmodule
